>>> design/yrc_pkg.sv
// shared types and constants of the yuy2 to rgb24 converter
// no dependencies; imported by every module of the block
package yrc_pkg;

  localparam int ByteW     = 8;
  localparam int TermW     = 18;  // signed width of luma and chroma products
  localparam int SumW      = 20;  // signed width of one channel sum
  localparam int OffsetW   = 24;
  localparam int CfgIdxW   = 2;
  localparam int CfgDataW  = 12;
  localparam int PairsRegW = 11;
  localparam int LinesRegW = 12;

  // register values after reset
  localparam int RstPairs = 640;
  localparam int RstLines = 480;

  // bt.601 integer coefficients and offsets
  localparam logic signed [TermW-1:0] LumaGain   = 18'sd298;
  localparam logic signed [TermW-1:0] RedFromV   = 18'sd409;
  localparam logic signed [TermW-1:0] GreenFromU = 18'sd100;
  localparam logic signed [TermW-1:0] GreenFromV = 18'sd208;
  localparam logic signed [TermW-1:0] BlueFromU  = 18'sd516;
  localparam logic signed [TermW-1:0] RoundBias  = 18'sd128;
  localparam logic        [9:0]       LumaOffset   = 10'd16;
  localparam logic        [9:0]       ChromaOffset = 10'd128;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_PAIRS_PER_LINE  = 2'd0,
    CFG_LINES_PER_FRAME = 2'd1
  } cfg_idx_e;

  typedef struct packed {
    logic                wr;
    logic [CfgIdxW-1:0]  index;
    logic [CfgDataW-1:0] data;
  } cfg_wr_t;

  // chroma terms shared by both lanes, rounding bias already added
  typedef struct packed {
    logic signed [TermW-1:0] red;
    logic signed [TermW-1:0] green;
    logic signed [TermW-1:0] blue;
  } chroma_t;

  typedef struct packed {
    logic [ByteW-1:0] blue;
    logic [ByteW-1:0] green;
    logic [ByteW-1:0] red;
  } pixel_t;

  typedef struct packed {
    logic [OffsetW-1:0] offset;
    logic               line_end;
    logic               frame_end;
  } pos_t;

endpackage

>>> design/yuy2_to_rgb24_converter.sv
// top level: yuy2 macropixel to two bgr pixels with bottom-up padded offsets
// depends on yrc_pkg, yrc_lane and yrc_addr
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+---------------------------------
//  in      | sink      | in_valid_i / in_stall_o    | luma_first, chroma_blue, luma_second,
//          |           |                            | chroma_red (8 bits each)
//  out     | source    | out_valid_o / out_stall_i  | three bytes per pixel x 2,
//          |           |                            | dest_offset (24), line_end, frame_end
//  cfg     | sink      | cfg_valid_i / cfg_ready_o  | cfg_index_i (2), cfg_data_i (12)
//
// one macropixel per clock while the output is not stalled; a result passes through
// the product register and then the clamp/output register of each lane
// reset restores 640 pairs x 480 lines and starts a new frame at the top line
// a stalled output holds; the input stalls only when both stages are full
// and the output is stalled
// a write to a known register restarts the frame; unknown indexes are dropped
module yuy2_to_rgb24_converter import yrc_pkg::*; #(
  parameter int MAX_PAIRS = 1024,
  parameter int MAX_LINES = 2048
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // item input
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [ByteW-1:0]    luma_first_i,
  input  logic [ByteW-1:0]    chroma_blue_i,
  input  logic [ByteW-1:0]    luma_second_i,
  input  logic [ByteW-1:0]    chroma_red_i,
  // result output
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [ByteW-1:0]    blue_first_o,
  output logic [ByteW-1:0]    green_first_o,
  output logic [ByteW-1:0]    red_first_o,
  output logic [ByteW-1:0]    blue_second_o,
  output logic [ByteW-1:0]    green_second_o,
  output logic [ByteW-1:0]    red_second_o,
  output logic [OffsetW-1:0]  dest_offset_o,
  output logic                line_end_o,
  output logic                frame_end_o,
  // register writes
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  // pipeline control: stage 1 holds products, stage 2 is the output register
  logic    s1_valid_q, s2_valid_q;
  logic    s1_ready, s2_ready, in_xfer, s2_load;

  // shared chroma terms and carried positions
  logic signed [9:0]       d_val, e_val;
  logic signed [TermW-1:0] d_ext, e_ext;
  chroma_t                 chroma_d, chroma_q;
  pos_t                    pos_now, s1_pos_q, s2_pos_q;
  cfg_wr_t                 cfg_wr;
  pixel_t                  pix_first, pix_second;

  assign s2_ready   = !s2_valid_q || !out_stall_i;
  assign s2_load    = s1_valid_q && s2_ready;
  assign s1_ready   = !s1_valid_q || s2_ready;
  assign in_xfer    = in_valid_i && s1_ready;
  assign in_stall_o = !s1_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_q <= in_valid_i;
      end
      if (s2_ready) begin
        s2_valid_q <= s1_valid_q;
      end
    end
  end

  // writes are always taken; ready is held high
  assign cfg_ready_o = 1'b1;
  always_comb begin
    cfg_wr.wr    = cfg_valid_i && cfg_ready_o;
    cfg_wr.index = cfg_index_i;
    cfg_wr.data  = cfg_data_i;
  end

  // chroma terms, computed once and shared by both lanes
  assign d_val = signed'({2'b00, chroma_blue_i} - ChromaOffset);
  assign e_val = signed'({2'b00, chroma_red_i} - ChromaOffset);
  assign d_ext = TermW'(d_val);
  assign e_ext = TermW'(e_val);

  always_comb begin
    chroma_d.red   = e_ext * RedFromV + RoundBias;
    chroma_d.green = RoundBias - d_ext * GreenFromU - e_ext * GreenFromV;
    chroma_d.blue  = d_ext * BlueFromU + RoundBias;
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      chroma_q <= chroma_d;
      s1_pos_q <= pos_now;
    end
    if (s2_load) begin
      s2_pos_q <= s1_pos_q;
    end
  end

  yrc_addr #(
    .MAX_PAIRS(MAX_PAIRS),
    .MAX_LINES(MAX_LINES)
  ) u_addr (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_wr),
    .adv_i (in_xfer),
    .pos_o (pos_now)
  );

  // one lane per pixel of the macropixel
  yrc_lane u_lane_first (
    .clk_i   (clk_i),
    .s1_en_i (in_xfer),
    .s2_en_i (s2_load),
    .luma_i  (luma_first_i),
    .chroma_i(chroma_q),
    .pix_o   (pix_first)
  );

  yrc_lane u_lane_second (
    .clk_i   (clk_i),
    .s1_en_i (in_xfer),
    .s2_en_i (s2_load),
    .luma_i  (luma_second_i),
    .chroma_i(chroma_q),
    .pix_o   (pix_second)
  );

  // merge both lanes with the position into one result
  assign out_valid_o    = s2_valid_q;
  assign blue_first_o   = pix_first.blue;
  assign green_first_o  = pix_first.green;
  assign red_first_o    = pix_first.red;
  assign blue_second_o  = pix_second.blue;
  assign green_second_o = pix_second.green;
  assign red_second_o   = pix_second.red;
  assign dest_offset_o  = s2_pos_q.offset;
  assign line_end_o     = s2_pos_q.line_end;
  assign frame_end_o    = s2_pos_q.frame_end;

endmodule

>>> design/yrc_lane.sv
// one pixel lane: luma product, channel sums, floor shift and clamp
// depends on yrc_pkg
module yrc_lane import yrc_pkg::*; (
  input  logic             clk_i,
  input  logic             s1_en_i,
  input  logic             s2_en_i,
  input  logic [ByteW-1:0] luma_i,
  input  chroma_t          chroma_i,
  output pixel_t           pix_o
);

  logic signed [9:0]       c_val;
  logic signed [TermW-1:0] prod_d, prod_q;
  logic signed [SumW-1:0]  sum_r, sum_g, sum_b;
  pixel_t                  pix_d, pix_q;

  function automatic logic [ByteW-1:0] shift_clamp(input logic signed [SumW-1:0] sum);
    logic [ByteW-1:0] res;
    if (sum[SumW-1]) begin
      res = '0;
    end else if (|sum[SumW-2:16]) begin
      res = '1;
    end else begin
      res = sum[15:8];
    end
    return res;
  endfunction

  assign c_val  = signed'({2'b00, luma_i} - LumaOffset);
  assign prod_d = TermW'(c_val) * LumaGain;

  always_ff @(posedge clk_i) begin
    if (s1_en_i) begin
      prod_q <= prod_d;
    end
  end

  assign sum_b = SumW'(prod_q) + SumW'(chroma_i.blue);
  assign sum_g = SumW'(prod_q) + SumW'(chroma_i.green);
  assign sum_r = SumW'(prod_q) + SumW'(chroma_i.red);

  always_comb begin
    pix_d.blue  = shift_clamp(sum_b);
    pix_d.green = shift_clamp(sum_g);
    pix_d.red   = shift_clamp(sum_r);
  end

  always_ff @(posedge clk_i) begin
    if (s2_en_i) begin
      pix_q <= pix_d;
    end
  end

  assign pix_o = pix_q;

endmodule

>>> design/yrc_addr.sv
// configuration registers and column/line counters for the destination offset
// depends on yrc_pkg
module yrc_addr import yrc_pkg::*; #(
  parameter int MAX_PAIRS = 1024,
  parameter int MAX_LINES = 2048
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cfg_wr_t cfg_i,
  input  logic    adv_i,
  output pos_t    pos_o
);

  localparam int EPW = $clog2(MAX_PAIRS + 1);
  localparam int ELW = $clog2(MAX_LINES + 1);
  localparam int PCW = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
  localparam int LIW = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
  localparam int SW  = EPW + 3;

  localparam int EffPRst    = (RstPairs > MAX_PAIRS) ? MAX_PAIRS : RstPairs;
  localparam int EffLRst    = (RstLines > MAX_LINES) ? MAX_LINES : RstLines;
  localparam int StrideRst  = ((EffPRst * 6 + 3) / 4) * 4;
  localparam int TopRst     = (StrideRst * (EffLRst - 1)) % (2 ** OffsetW);

  function automatic logic [EPW-1:0] eff_pairs(input logic [PairsRegW-1:0] v);
    logic [EPW-1:0] res;
    if (v == '0) begin
      res = EPW'(1);
    end else if (int'(v) > MAX_PAIRS) begin
      res = EPW'(MAX_PAIRS);
    end else begin
      res = EPW'(v);
    end
    return res;
  endfunction

  function automatic logic [ELW-1:0] eff_lines(input logic [LinesRegW-1:0] v);
    logic [ELW-1:0] res;
    if (v == '0) begin
      res = ELW'(1);
    end else if (int'(v) > MAX_LINES) begin
      res = ELW'(MAX_LINES);
    end else begin
      res = ELW'(v);
    end
    return res;
  endfunction

  logic [PairsRegW-1:0] pairs_d, pairs_q;
  logic [LinesRegW-1:0] lines_d, lines_q;
  logic [EPW-1:0]       eff_p_d, eff_p_q;
  logic [ELW-1:0]       eff_l_d, eff_l_q;
  logic [SW-1:0]        stride_d, stride_q, six_p;
  logic [OffsetW-1:0]   top_d, top_q;
  logic [PCW-1:0]       col_d, col_q;
  logic [LIW-1:0]       line_d, line_q;
  logic [OffsetW-1:0]   base_d, base_q;
  logic                 cfg_hit, lend, fend;

  // new register values and the top line base they imply
  always_comb begin
    pairs_d = pairs_q;
    lines_d = lines_q;
    cfg_hit = 1'b0;
    if (cfg_i.wr) begin
      unique case (cfg_i.index)
        CFG_PAIRS_PER_LINE: begin
          pairs_d = cfg_i.data[PairsRegW-1:0];
          cfg_hit = 1'b1;
        end
        CFG_LINES_PER_FRAME: begin
          lines_d = cfg_i.data[LinesRegW-1:0];
          cfg_hit = 1'b1;
        end
        default: cfg_hit = 1'b0;
      endcase
    end
    eff_p_d  = eff_pairs(pairs_d);
    eff_l_d  = eff_lines(lines_d);
    six_p    = (SW'(eff_p_d) << 2) + (SW'(eff_p_d) << 1);
    stride_d = (six_p + SW'(3)) & ~SW'(3);
    // product taken at the full offset width so the top base cannot overflow
    top_d    = OffsetW'(stride_d) * OffsetW'(eff_l_d - ELW'(1));
  end

  // position of the pair being accepted
  assign lend = (EPW'(col_q) >= (eff_p_q - EPW'(1)));
  assign fend = lend && (ELW'(line_q) >= (eff_l_q - ELW'(1)));

  always_comb begin
    pos_o.offset    = base_q + (OffsetW'(col_q) << 2) + (OffsetW'(col_q) << 1);
    pos_o.line_end  = lend;
    pos_o.frame_end = fend;
  end

  always_comb begin
    col_d  = col_q;
    line_d = line_q;
    base_d = base_q;
    if (cfg_hit) begin
      col_d  = '0;
      line_d = '0;
      base_d = top_d;
    end else if (adv_i) begin
      if (fend) begin
        col_d  = '0;
        line_d = '0;
        base_d = top_q;
      end else if (lend) begin
        col_d  = '0;
        line_d = line_q + 1'b1;
        base_d = base_q - OffsetW'(stride_q);
      end else begin
        col_d  = col_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pairs_q  <= PairsRegW'(RstPairs);
      lines_q  <= LinesRegW'(RstLines);
      eff_p_q  <= EPW'(EffPRst);
      eff_l_q  <= ELW'(EffLRst);
      stride_q <= SW'(StrideRst);
      top_q    <= OffsetW'(TopRst);
      col_q    <= '0;
      line_q   <= '0;
      base_q   <= OffsetW'(TopRst);
    end else begin
      if (cfg_hit) begin
        pairs_q  <= pairs_d;
        lines_q  <= lines_d;
        eff_p_q  <= eff_p_d;
        eff_l_q  <= eff_l_d;
        stride_q <= stride_d;
        top_q    <= top_d;
      end
      col_q  <= col_d;
      line_q <= line_d;
      base_q <= base_d;
    end
  end

endmodule

>>> sim/tb.sv
// self-checking testbench of yuy2_to_rgb24_converter: macropixel to bgr pair conversion
// depends on yrc_pkg and the converter rtl; has its own bt.601 and image position predictor

module tb import yrc_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MaxPairs    = 1024;
  localparam int MaxLines    = 2048;
  localparam int PipeDepth   = 2;     // depth of the block: product register, then output register
  localparam int HoldOffLen  = 60;    // long receiver hold-off, in cycles
  localparam int WatchdogMax = 2000;  // cycles without any transfer before giving up
  localparam int RandomItems = 560;

  // indexes with no register behind them
  localparam logic [CfgIdxW-1:0] CfgSpareLo = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgSpareHi = 2'd3;

  // one expected result: both pixels and the position in the image
  typedef struct packed {
    pixel_t first;
    pixel_t second;
    pos_t   pos;
  } bgr_pair_t;

  // directed stimulus row; pixels typed in only where known is set
  typedef struct packed {
    logic [ByteW-1:0] y0;
    logic [ByteW-1:0] u;
    logic [ByteW-1:0] y1;
    logic [ByteW-1:0] v;
    logic             known;
    pixel_t           first;
    pixel_t           second;
  } probe_t;

  localparam pixel_t PixBlack = '0;
  localparam pixel_t PixWhite = '1;
  localparam pixel_t PixOne   = '{8'd1, 8'd1, 8'd1};

  localparam probe_t Probes [16] = '{
    // neutral chroma: every channel equals the luma term
    '{8'd16,  8'd128, 8'd16,  8'd128, 1'b1, PixBlack, PixBlack},
    '{8'd235, 8'd128, 8'd235, 8'd128, 1'b1, PixWhite, PixWhite},
    '{8'd0,   8'd128, 8'd255, 8'd128, 1'b1, PixBlack, PixWhite},
    '{8'd255, 8'd128, 8'd0,   8'd128, 1'b1, PixWhite, PixBlack},
    // just below black floors to zero, one step above black rounds to one
    '{8'd15,  8'd128, 8'd17,  8'd128, 1'b1, PixBlack, PixOne},
    // chroma extremes in every combination
    '{8'd128, 8'd0,   8'd128, 8'd0,   1'b0, PixBlack, PixBlack},
    '{8'd128, 8'd255, 8'd128, 8'd255, 1'b0, PixBlack, PixBlack},
    '{8'd128, 8'd0,   8'd128, 8'd255, 1'b0, PixBlack, PixBlack},
    '{8'd128, 8'd255, 8'd128, 8'd0,   1'b0, PixBlack, PixBlack},
    '{8'd0,   8'd0,   8'd0,   8'd0,   1'b0, PixBlack, PixBlack},
    '{8'd255, 8'd255, 8'd255, 8'd255, 1'b0, PixBlack, PixBlack},
    // alternating bit patterns, then mixed values
    '{8'hAA,  8'h55,  8'h55,  8'hAA,  1'b0, PixBlack, PixBlack},
    '{8'h55,  8'hAA,  8'hAA,  8'h55,  1'b0, PixBlack, PixBlack},
    '{8'd16,  8'd0,   8'd235, 8'd255, 1'b0, PixBlack, PixBlack},
    '{8'd81,  8'd90,  8'd81,  8'd240, 1'b0, PixBlack, PixBlack},
    '{8'd255, 8'd0,   8'd0,   8'd255, 1'b0, PixBlack, PixBlack}
  };

  // dut signals, known from time zero
  logic                clk_i          = 1'b0;
  logic                rst_ni         = 1'b0;
  logic                in_valid_i     = 1'b0;
  logic                in_stall_o;
  logic [ByteW-1:0]    luma_first_i   = '0;
  logic [ByteW-1:0]    chroma_blue_i  = '0;
  logic [ByteW-1:0]    luma_second_i  = '0;
  logic [ByteW-1:0]    chroma_red_i   = '0;
  logic                out_valid_o;
  logic                out_stall_i    = 1'b0;
  logic [ByteW-1:0]    blue_first_o;
  logic [ByteW-1:0]    green_first_o;
  logic [ByteW-1:0]    red_first_o;
  logic [ByteW-1:0]    blue_second_o;
  logic [ByteW-1:0]    green_second_o;
  logic [ByteW-1:0]    red_second_o;
  logic [OffsetW-1:0]  dest_offset_o;
  logic                line_end_o;
  logic                frame_end_o;
  logic                cfg_valid_i    = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i    = '0;
  logic [CfgDataW-1:0] cfg_data_i     = '0;

  // predictor state: register copies and image position
  logic [PairsRegW-1:0] pairs_reg;
  logic [LinesRegW-1:0] lines_reg;
  int unsigned          pair_col;
  int unsigned          line_row;
  logic [OffsetW-1:0]   line_origin;

  bgr_pair_t pending_pairs [$];  // expected results in transfer order
  int        failures     = 0;
  int        items_sent   = 0;
  bit        idle_en      = 1'b0;  // random gaps on both sides
  bit        hold_off_req = 1'b0;  // one long receiver hold-off
  int        quiet_cycles = 0;

  yuy2_to_rgb24_converter #(
    .MAX_PAIRS(MaxPairs),
    .MAX_LINES(MaxLines)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .luma_first_i  (luma_first_i),
    .chroma_blue_i (chroma_blue_i),
    .luma_second_i (luma_second_i),
    .chroma_red_i  (chroma_red_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .blue_first_o  (blue_first_o),
    .green_first_o (green_first_o),
    .red_first_o   (red_first_o),
    .blue_second_o (blue_second_o),
    .green_second_o(green_second_o),
    .red_second_o  (red_second_o),
    .dest_offset_o (dest_offset_o),
    .line_end_o    (line_end_o),
    .frame_end_o   (frame_end_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // zero acts as one, anything above the maximum acts as the maximum
  function automatic int unsigned active_pairs();
    if (pairs_reg == 0) return 1;
    if (pairs_reg > MaxPairs) return MaxPairs;
    return 32'(pairs_reg);
  endfunction

  function automatic int unsigned active_lines();
    if (lines_reg == 0) return 1;
    if (lines_reg > MaxLines) return MaxLines;
    return 32'(lines_reg);
  endfunction

  // bytes per line, padded up to a multiple of four
  function automatic int unsigned line_stride();
    return ((active_pairs() * 6 + 3) / 4) * 4;
  endfunction

  // bottom-up image: the first line sits at the highest base
  function automatic void rewind_frame();
    pair_col    = 0;
    line_row    = 0;
    line_origin = OffsetW'(line_stride() * (active_lines() - 1));
  endfunction

  function automatic void load_register(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    if (idx == CFG_PAIRS_PER_LINE) begin
      pairs_reg = data[PairsRegW-1:0];
    end else if (idx == CFG_LINES_PER_FRAME) begin
      lines_reg = data[LinesRegW-1:0];
    end else begin
      return;  // unknown index leaves the frame running
    end
    rewind_frame();
  endfunction

  // floor shift by 8, then clamp into a byte
  function automatic logic [ByteW-1:0] clamp_channel(int sum);
    int scaled;
    scaled = sum >>> 8;
    if (scaled < 0) return '0;
    if (scaled > 255) return '1;
    return scaled[ByteW-1:0];
  endfunction

  function automatic pixel_t shade_pixel(int luma_term, int red_t, int green_t, int blue_t);
    pixel_t px;
    px.blue  = clamp_channel(luma_term + blue_t);
    px.green = clamp_channel(luma_term + green_t);
    px.red   = clamp_channel(luma_term + red_t);
    return px;
  endfunction

  // bt.601 conversion of one macropixel plus its place in the frame;
  // advances the column, line and base as the block does
  function automatic bgr_pair_t convert_macropixel(logic [ByteW-1:0] y0, logic [ByteW-1:0] u,
                                                   logic [ByteW-1:0] y1, logic [ByteW-1:0] v);
    bgr_pair_t res;
    int        du, dv, red_t, green_t, blue_t;
    bit        last_col, last_row;
    du      = int'(u) - int'(ChromaOffset);
    dv      = int'(v) - int'(ChromaOffset);
    red_t   = int'(RedFromV) * dv + int'(RoundBias);
    green_t = int'(RoundBias) - int'(GreenFromU) * du - int'(GreenFromV) * dv;
    blue_t  = int'(BlueFromU) * du + int'(RoundBias);
    res.first  = shade_pixel(int'(LumaGain) * (int'(y0) - int'(LumaOffset)),
                             red_t, green_t, blue_t);
    res.second = shade_pixel(int'(LumaGain) * (int'(y1) - int'(LumaOffset)),
                             red_t, green_t, blue_t);
    last_col = (pair_col >= active_pairs() - 1);
    last_row = last_col && (line_row >= active_lines() - 1);
    res.pos.offset    = line_origin + OffsetW'(6 * pair_col);
    res.pos.line_end  = last_col;
    res.pos.frame_end = last_row;
    if (last_row) begin
      rewind_frame();
    end else if (last_col) begin
      pair_col    = 0;
      line_row    = line_row + 1;
      line_origin = line_origin - OffsetW'(line_stride());
    end else begin
      pair_col = pair_col + 1;
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------

  // one macropixel transfer; typed-in pixels replace the predicted ones
  task automatic send_macropixel(input logic [ByteW-1:0] y0, input logic [ByteW-1:0] u,
                                 input logic [ByteW-1:0] y1, input logic [ByteW-1:0] v,
                                 input bit known = 1'b0,
                                 input pixel_t first = '0, input pixel_t second = '0);
    bgr_pair_t want;
    // occasional sender gap
    if (idle_en && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    luma_first_i  <= y0;
    chroma_blue_i <= u;
    luma_second_i <= y1;
    chroma_red_i  <= v;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    // transfer taken at this edge
    want = convert_macropixel(y0, u, y1, v);
    if (known) begin
      want.first  = first;
      want.second = second;
    end
    pending_pairs.push_back(want);
    items_sent++;
  endtask

  task automatic send_random(input int count);
    repeat (count) begin
      send_macropixel(ByteW'($urandom), ByteW'($urandom), ByteW'($urandom), ByteW'($urandom));
    end
  endtask

  // stop sending and wait until every result is out and the pipe is empty
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending_pairs.size() != 0) @(posedge clk_i);
    repeat (PipeDepth + 2) @(posedge clk_i);
  endtask

  // register write; valid stays high for back-to-back writes until the last one
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data,
                           input bit last);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    load_register(idx, data);
    if (last) cfg_valid_i <= 1'b0;
  endtask

  task automatic set_geometry(input logic [CfgDataW-1:0] pairs, input logic [CfgDataW-1:0] lines);
    write_reg(CFG_PAIRS_PER_LINE, pairs, 1'b0);
    write_reg(CFG_LINES_PER_FRAME, lines, 1'b1);
  endtask

  // ---------------------------------------------------------------------------
  // receiver: random stall bursts and one long hold-off
  // ---------------------------------------------------------------------------
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        // the block fills and stalls its input while the sender keeps offering
        hold_off_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HoldOffLen) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 4)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result checker
  // ---------------------------------------------------------------------------
  task automatic check_field(input string what, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      failures++;
    end
  endtask

  always @(posedge clk_i) begin
    bgr_pair_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_pairs.size() == 0) begin
        $display("%0t: result transfer with nothing expected, offset %0d",
                 $time, dest_offset_o);
        failures++;
      end else begin
        want = pending_pairs.pop_front();
        check_field("blue_first",   32'(want.first.blue),    32'(blue_first_o));
        check_field("green_first",  32'(want.first.green),   32'(green_first_o));
        check_field("red_first",    32'(want.first.red),     32'(red_first_o));
        check_field("blue_second",  32'(want.second.blue),   32'(blue_second_o));
        check_field("green_second", 32'(want.second.green),  32'(green_second_o));
        check_field("red_second",   32'(want.second.red),    32'(red_second_o));
        check_field("dest_offset",  32'(want.pos.offset),    32'(dest_offset_o));
        check_field("line_end",     32'(want.pos.line_end),  32'(line_end_o));
        check_field("frame_end",    32'(want.pos.frame_end), 32'(frame_end_o));
      end
    end
  end

  // watchdog: cycles in a row without any transfer on any channel
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o) || !rst_ni) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogMax) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned pairs_pick, lines_pick;
    pairs_reg = PairsRegW'(RstPairs);
    lines_reg = LinesRegW'(RstLines);
    rewind_frame();

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed rows at the reset geometry, 640 x 480
    foreach (Probes[i]) begin
      send_macropixel(Probes[i].y0, Probes[i].u, Probes[i].y1, Probes[i].v,
                      Probes[i].known, Probes[i].first, Probes[i].second);
    end
    drain_results();

    // zero registers act as one: every pair ends its line and its frame
    idle_en = 1'b1;
    set_geometry('0, '0);
    send_random(24);
    drain_results();

    // all data bits set: both registers saturate at the maxima, top offset
    set_geometry('1, '1);
    send_random(20);
    drain_results();

    // exact maximum width, one line: a few pairs at the widest stride
    set_geometry(CfgDataW'(MaxPairs), 12'd1);
    send_random(12);
    drain_results();

    // narrowest lines in the tallest frame
    set_geometry(12'd1, CfgDataW'(MaxLines));
    send_random(30);
    drain_results();

    // odd width so the stride needs padding; a write to an unknown index
    // mid-frame must not restart the frame
    set_geometry(12'd3, 12'd4);
    send_random(5);
    drain_results();
    write_reg(CfgSpareLo, '1, 1'b0);
    write_reg(CfgSpareHi, 12'h555, 1'b1);
    send_random(20);
    drain_results();

    // single register write mid-frame restarts it
    send_random(3);
    drain_results();
    write_reg(CFG_LINES_PER_FRAME, 12'd5, 1'b1);
    send_random(15);
    drain_results();

    // long receiver hold-off while the sender keeps going
    set_geometry(12'd2, 12'd3);
    hold_off_req = 1'b1;
    send_random(40);
    drain_results();

    // random small geometries, some phases without gaps
    while (items_sent < RandomItems) begin
      idle_en    = ($urandom_range(0, 3) != 0);
      pairs_pick = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 40) : $urandom_range(1, 6);
      lines_pick = $urandom_range(0, 5);
      case ($urandom_range(0, 3))
        0: write_reg(CFG_PAIRS_PER_LINE, CfgDataW'(pairs_pick), 1'b1);
        1: write_reg(CFG_LINES_PER_FRAME, CfgDataW'(lines_pick), 1'b1);
        2: begin
          write_reg(CFG_LINES_PER_FRAME, CfgDataW'(lines_pick), 1'b0);
          write_reg(CFG_PAIRS_PER_LINE, CfgDataW'(pairs_pick), 1'b1);
        end
        default: set_geometry(CfgDataW'(pairs_pick), CfgDataW'(lines_pick));
      endcase
      send_random($urandom_range(10, 60));
      drain_results();
    end

    // last stretch at full rate, no gaps on either side
    idle_en = 1'b0;
    set_geometry(12'd5, 12'd3);
    send_random(60);
    drain_results();
    repeat (PipeDepth + 4) @(posedge clk_i);

    if (failures == 0 && pending_pairs.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> files.f
design/yrc_pkg.sv
design/yrc_lane.sv
design/yrc_addr.sv
design/yuy2_to_rgb24_converter.sv
sim/tb.sv
